/* design/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int FILL_W = 5;

    typedef enum logic [1:0] {
        FN_PUSH_FRONT = 2'd0,
        FN_PUSH_BACK  = 2'd1,
        FN_POP_FRONT  = 2'd2,
        FN_POP_BACK   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic             we;     // operation takes effect this cycle
        func_t            func;
        logic [CNT_W-1:0] count;  // entries held before the operation
    } cell_ctrl_t;

endpackage

/* design/deq_cell.sv */
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row. Shifts toward the back on a front push,
// toward the front on a front pop, and loads the pushed value when it is the
// first free slot on a back push.
// ----------------------------------------------------------------------------
module deq_cell (
    input  logic                          clk,
    input  deq_pkg::cell_ctrl_t           ctrl,
    input  logic [deq_pkg::IDX_W-1:0]     cell_idx,
    input  logic signed [deq_pkg::DATA_W-1:0] left_data,
    input  logic signed [deq_pkg::DATA_W-1:0] right_data,
    input  logic signed [deq_pkg::DATA_W-1:0] push_value,
    output logic signed [deq_pkg::DATA_W-1:0] data,
    output logic signed [deq_pkg::DATA_W-1:0] tap
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic [CNT_W-1:0]         idx_ext;
    logic                     is_free_slot;
    logic                     is_last;

    assign idx_ext      = CNT_W'(cell_idx);
    assign is_free_slot = (idx_ext == ctrl.count);
    assign is_last      = (CNT_W'(idx_ext + CNT_W'(1)) == ctrl.count);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.we)
        begin
            case (ctrl.func)
                FN_PUSH_FRONT: data_next = left_data;
                FN_PUSH_BACK:  if (is_free_slot) data_next = push_value;
                FN_POP_FRONT:  data_next = right_data;
                default:       data_next = data_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // only the back entry drives the shared pop-back tap
    assign tap  = is_last ? data_reg : '0;

endmodule

/* design/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values built as a row of shifting cells.
// ----------------------------------------------------------------------------
// One item per clock while in_stall is low: every accepted beat updates the
// whole cell row (front operations shift the row, back operations touch the
// cell at the fill boundary), and its result appears in the output register
// on the next cycle. in_stall rises only while a result is held and out_stall
// is high. The front entry always sits in cell 0; the back entry sits in cell
// fill_level-1. Contents of cells never written are unspecified.
module double_ended_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        func,
    input  logic signed [deq_pkg::DATA_W-1:0] push_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [deq_pkg::DATA_W-1:0] pop_value,
    output logic [1:0]                        status,
    output logic [deq_pkg::FILL_W-1:0]        fill_level
);
    import deq_pkg::*;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] pop_value_reg;
    logic [1:0]               status_reg;
    logic [FILL_W-1:0]        fill_reg;

    logic                     fire;
    func_t                    fn;
    logic                     is_push;
    logic                     full;
    logic                     empty;
    logic                     op_ok;
    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] cell_tap  [DEPTH];
    logic signed [DATA_W-1:0] back_value;
    logic signed [DATA_W-1:0] res_value;
    status_t                  res_status;

    assign in_stall = out_valid_reg && out_stall;
    assign fire     = in_valid && !in_stall;
    assign fn       = func_t'(func);
    assign is_push  = (fn == FN_PUSH_FRONT) || (fn == FN_PUSH_BACK);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign op_ok    = is_push ? !full : !empty;

    assign ctrl.we    = fire && op_ok;
    assign ctrl.func  = fn;
    assign ctrl.count = count_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_in;
            logic signed [DATA_W-1:0] right_in;
            if (gi == 0)
            begin : g_first
                assign left_in = push_value;
            end
            else
            begin : g_mid_l
                assign left_in = cell_data[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_in = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_in = cell_data[gi+1];
            end

            deq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .cell_idx   (IDX_W'(gi)),
                .left_data  (left_in),
                .right_data (right_in),
                .push_value (push_value),
                .data       (cell_data[gi]),
                .tap        (cell_tap[gi])
            );
        end
    endgenerate

    always_comb
    begin
        back_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_value = back_value | cell_tap[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        res_value  = '0;
        res_status = ST_OK;
        if (!op_ok)
        begin
            res_status = is_push ? ST_FULL : ST_EMPTY;
        end
        else
        begin
            case (fn) inside
                FN_PUSH_FRONT, FN_PUSH_BACK: count_next = count_reg + CNT_W'(1);
                FN_POP_FRONT:
                begin
                    count_next = count_reg - CNT_W'(1);
                    res_value  = cell_data[0];
                end
                default:
                begin
                    count_next = count_reg - CNT_W'(1);
                    res_value  = back_value;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg <= count_next;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pop_value_reg <= res_value;
            status_reg    <= res_status;
            fill_reg      <= FILL_W'(count_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign pop_value  = pop_value_reg;
    assign status     = status_reg;
    assign fill_level = fill_reg;

endmodule

/* design/deq_checker.sv */
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [deq_pkg::DATA_W-1:0] pop_value,
    input  logic [1:0]                        status,
    input  logic [deq_pkg::FILL_W-1:0]        fill_level
);
    import deq_pkg::*;

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pop_value)
            && $stable(status) && $stable(fill_level))
        else $error("result beat changed while stalled");

    // each accepted beat yields a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted beat gave no result");

    // input is only held off by a stalled result
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && out_stall) |-> !in_stall)
        else $error("input stalled with free output slot");

    a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> fill_level == FILL_W'(DEPTH)
            && pop_value == '0)
        else $error("full status with wrong level or value");

    a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> fill_level == '0 && pop_value == '0)
        else $error("empty status with wrong level or value");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

/* dv/tb_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking testbench for the bounded double-ended queue. A shadow ring
// (head index plus entry count) predicts every result beat. Directed tests
// cover pops on empty, extreme values, filling to full and pushes refused
// when full. A long receiver hold-off then backs up the input. Random traffic
// follows in segments biased toward pushes, pops or neither, so the queue
// repeatedly runs between empty and full, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
    import deq_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_OFF      = 60;
    localparam int RANDOM_BEATS  = 1300;
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        status_t                  st;
        logic [FILL_W-1:0]        fill;
    } outcome_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               func;
    logic signed [DATA_W-1:0] push_value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] pop_value;
    logic [1:0]               status;
    logic [FILL_W-1:0]        fill_level;

    // shadow deque
    logic signed [DATA_W-1:0] shadow_store [DEPTH];
    int                       shadow_head;
    int                       shadow_count;
    outcome_t                 queued_outcomes [$];

    bit gaps_on;
    int hold_off_cycles;
    int cycle_count;
    int mismatches;
    int beats_seen;
    int full_drops;
    int empty_pops;
    int peak_fill;

    double_ended_queue u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pop_value  (pop_value),
        .status     (status),
        .fill_level (fill_level)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("double_ended_queue test failed");
            $finish;
        end
    end

    function automatic outcome_t shadow_apply(func_t op, logic signed [DATA_W-1:0] v);
        outcome_t r;
        int       slot;
        r.value = '0;
        r.st    = ST_OK;
        if (op == FN_PUSH_FRONT || op == FN_PUSH_BACK)
        begin
            if (shadow_count >= DEPTH)
                r.st = ST_FULL;
            else
            begin
                if (op == FN_PUSH_FRONT)
                begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    slot        = shadow_head;
                end
                else
                    slot = (shadow_head + shadow_count) % DEPTH;
                shadow_store[slot] = v;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
                r.st = ST_EMPTY;
            else
            begin
                if (op == FN_POP_FRONT)
                begin
                    slot        = shadow_head;
                    shadow_head = (shadow_head + 1) % DEPTH;
                end
                else
                    slot = (shadow_head + shadow_count - 1) % DEPTH;
                r.value = shadow_store[slot];
                shadow_count--;
            end
        end
        r.fill = shadow_count[FILL_W-1:0];
        if (shadow_count > peak_fill)
            peak_fill = shadow_count;
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic func_t pick_op(int push_pct);
        bit back_end;
        back_end = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < push_pct)
            return back_end ? FN_PUSH_BACK : FN_PUSH_FRONT;
        return back_end ? FN_POP_BACK : FN_POP_FRONT;
    endfunction

    // Presents one beat and returns right after the edge that accepts it;
    // valid stays up until the next call or bus_idle.
    task automatic send_beat(func_t op, logic signed [DATA_W-1:0] v);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= op;
        push_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        queued_outcomes.push_back(shadow_apply(op, v));
    endtask

    task automatic bus_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic test_empty_pops();
        send_beat(FN_POP_FRONT, pick_value());
        send_beat(FN_POP_BACK, pick_value());
        bus_idle();
    endtask

    task automatic test_edge_values();
        send_beat(FN_PUSH_FRONT, VAL_MAX);
        send_beat(FN_PUSH_BACK, VAL_MIN);
        send_beat(FN_PUSH_FRONT, '1);
        send_beat(FN_PUSH_BACK, '0);
        send_beat(FN_POP_FRONT, VAL_MIN);
        send_beat(FN_POP_BACK, VAL_MAX);
        bus_idle();
    endtask

    task automatic test_full_queue();
        bit flip;
        flip = 1'b0;
        while (shadow_count < DEPTH)
        begin
            send_beat(flip ? FN_PUSH_BACK : FN_PUSH_FRONT, pick_value());
            flip = !flip;
        end
        send_beat(FN_PUSH_FRONT, pick_value());
        send_beat(FN_PUSH_BACK, pick_value());
        send_beat(FN_POP_FRONT, pick_value());
        send_beat(FN_POP_BACK, pick_value());
        bus_idle();
    endtask

    // receiver stops for a long stretch; the sender keeps offering beats
    task automatic test_backpressure();
        gaps_on = 1'b0;
        @(posedge clk);
        hold_off_cycles = HOLD_OFF;
        repeat (24)
            send_beat(pick_op(50), pick_value());
        bus_idle();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic(int total);
        int sent;
        int seg_len;
        int push_pct;
        sent = 0;
        while (sent < total)
        begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       push_pct = 15;
                1:       push_pct = 50;
                default: push_pct = 85;
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat (seg_len)
            begin
                send_beat(pick_op(push_pct), pick_value());
                sent++;
            end
        end
        bus_idle();
        gaps_on = 1'b1;
    endtask

    initial
    begin : result_receiver
        int wait_left;
        wait_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                wait_left = gaps_on ? $urandom_range(0, 5) : 0;
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_stall <= 1'b1;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_seen++;
            if (queued_outcomes.size() == 0)
            begin
                $error("unexpected result beat: pop_value %0d status %0d fill_level %0d",
                       pop_value, status, fill_level);
                mismatches++;
            end
            else
            begin
                want = queued_outcomes.pop_front();
                if (pop_value !== want.value)
                begin
                    $error("pop_value: expected %0d, got %0d", want.value, pop_value);
                    mismatches++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    mismatches++;
                end
                if (fill_level !== want.fill)
                begin
                    $error("fill_level: expected %0d, got %0d", want.fill, fill_level);
                    mismatches++;
                end
                if (want.st == ST_FULL)
                    full_drops++;
                if (want.st == ST_EMPTY)
                    empty_pops++;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FN_PUSH_FRONT;
        push_value   = '0;
        gaps_on      = 1'b1;
        shadow_head  = 0;
        shadow_count = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_empty_pops();
        test_edge_values();
        test_full_queue();
        test_backpressure();
        test_random_traffic(RANDOM_BEATS);

        while (queued_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d result beats; peak fill %0d of %0d, %0d pushes refused when full,",
                 beats_seen, peak_fill, DEPTH, full_drops);
        $display("%0d pops on empty, a %0d-cycle receiver hold-off, %0d mismatches.",
                 empty_pops, HOLD_OFF, mismatches);
        if (mismatches == 0)
            $display("double_ended_queue test passed");
        else
            $display("double_ended_queue test failed");
        $finish;
    end

endmodule
